>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/tjpid_pkg.sv
// ----------------------------------------------------------------------------
// tjpid_pkg
// Widths, register indexes and state layout of the two-joint PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package tjpid_pkg;

   localparam int JOINT_W    = 1;
   localparam int ANGLE_W    = 16;
   localparam int ERR_W      = ANGLE_W + 1;
   localparam int QUOT_W     = 14;
   localparam int GAIN_W     = 24;
   localparam int DB_W       = 8;
   localparam int INTEG_W    = 32;
   localparam int DRIVE_W    = 32;
   localparam int FRAC_BITS  = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int PD_PROD_W  = GAIN_W + 1 + ERR_W;
   localparam int I_PROD_W   = GAIN_W + 1 + INTEG_W;
   localparam int ACC_W      = I_PROD_W + 2;
   localparam int SHIFT_W    = ACC_W - FRAC_BITS;

   // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for every 16-bit x
   localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [JOINT_W-1:0] JOINT_SHOULDER = 1'b0;
   localparam logic [JOINT_W-1:0] JOINT_ELBOW    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_KP_SHOULDER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI_SHOULDER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD_SHOULDER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KP_ELBOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KI_ELBOW    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KD_ELBOW    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND    = 3'd6;

   localparam logic [GAIN_W-1:0] KP_SHOULDER_RST = 24'd737280;
   localparam logic [GAIN_W-1:0] KI_SHOULDER_RST = 24'd492;
   localparam logic [GAIN_W-1:0] KD_SHOULDER_RST = 24'd0;
   localparam logic [GAIN_W-1:0] KP_ELBOW_RST    = 24'd327680;
   localparam logic [GAIN_W-1:0] KI_ELBOW_RST    = 24'd164;
   localparam logic [GAIN_W-1:0] KD_ELBOW_RST    = 24'd0;
   localparam logic [DB_W-1:0]   DEADBAND_RST    = 8'd5;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] setpoint;
      logic signed [INTEG_W-1:0] integral;
      logic signed [ANGLE_W-1:0] last_pos;
   } joint_state_type;

endpackage

`default_nettype wire

>>> rtl/two_joint_pid_with_deadband.sv
// ----------------------------------------------------------------------------
// two_joint_pid_with_deadband
// Two-channel PID step with proportional deadband and saturating integral.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle unless the result side stalls, and returns
// one drive value per transaction, in order, through five register stages;
// a stall holds each stage in turn back to req_ready. Per-joint state
// (setpoint, integral, last position) lives in a two-entry memory read at
// acceptance and written back as the transaction leaves stage 1; a same-joint
// transaction right behind is served from a forwarding register, so joints
// may be mixed freely at full rate. Gains and deadband are to be written
// through the csr port only while no transaction is in flight; the block does
// not enforce this, and csr writes are always taken.
`default_nettype none

module two_joint_pid_with_deadband (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [tjpid_pkg::JOINT_W-1:0]        req_joint,
   input  wire logic signed [tjpid_pkg::ANGLE_W-1:0] req_setpoint,
   input  wire logic signed [tjpid_pkg::ANGLE_W-1:0] req_measured,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [tjpid_pkg::DRIVE_W-1:0]      rsp_drive,
   output logic [tjpid_pkg::JOINT_W-1:0]             rsp_out_joint,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tjpid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tjpid_pkg::CSR_DATA_W-1:0]     csr_data
);
   import tjpid_pkg::*;

   `include "assert_macros.svh"

   // configuration
   logic [GAIN_W-1:0] kp_shoulder_ff, ki_shoulder_ff, kd_shoulder_ff;
   logic [GAIN_W-1:0] kp_elbow_ff, ki_elbow_ff, kd_elbow_ff;
   logic [DB_W-1:0]   deadband_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_shoulder_ff <= KP_SHOULDER_RST;
         ki_shoulder_ff <= KI_SHOULDER_RST;
         kd_shoulder_ff <= KD_SHOULDER_RST;
         kp_elbow_ff    <= KP_ELBOW_RST;
         ki_elbow_ff    <= KI_ELBOW_RST;
         kd_elbow_ff    <= KD_ELBOW_RST;
         deadband_ff    <= DEADBAND_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_KP_SHOULDER: kp_shoulder_ff <= csr_data[GAIN_W-1:0];
            REG_KI_SHOULDER: ki_shoulder_ff <= csr_data[GAIN_W-1:0];
            REG_KD_SHOULDER: kd_shoulder_ff <= csr_data[GAIN_W-1:0];
            REG_KP_ELBOW:    kp_elbow_ff    <= csr_data[GAIN_W-1:0];
            REG_KI_ELBOW:    ki_elbow_ff    <= csr_data[GAIN_W-1:0];
            REG_KD_ELBOW:    kd_elbow_ff    <= csr_data[GAIN_W-1:0];
            REG_DEADBAND:    deadband_ff    <= csr_data[DB_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic rsp_en, s4_ready, s3_ready, s2_ready, s1_ready, req_fire, wr_en;

   assign rsp_en    = !rsp_valid_ff || rsp_ready;
   assign s4_ready  = !s4_valid_ff || rsp_en;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign req_fire  = req_valid && req_ready;
   assign wr_en     = s1_valid_ff && s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff  <= req_valid;
         if (s2_ready) s2_valid_ff  <= s1_valid_ff;
         if (s3_ready) s3_valid_ff  <= s2_valid_ff;
         if (s4_ready) s4_valid_ff  <= s3_valid_ff;
         if (rsp_en)   rsp_valid_ff <= s4_valid_ff;
      end
   end

   // stage 0: error, deadband, error / 10
   logic signed [ERR_W-1:0]  err_in;
   logic [ERR_W-1:0]         mag_in;
   logic [31:0]              quot_prod_in;
   logic [QUOT_W-1:0]        quot_mag_in;
   logic signed [QUOT_W-1:0] quot_in;
   logic signed [ERR_W-1:0]  ep_in;

   always_comb begin
      err_in       = {req_setpoint[ANGLE_W-1], req_setpoint}
                   - {req_measured[ANGLE_W-1], req_measured};
      mag_in       = err_in[ERR_W-1] ? -err_in : err_in;
      quot_prod_in = mag_in[ANGLE_W-1:0] * RECIP_TEN;
      quot_mag_in  = {1'b0, quot_prod_in[31:RECIP_SHIFT]};
      quot_in      = err_in[ERR_W-1] ? -quot_mag_in : quot_mag_in;
      ep_in        = (mag_in < {{(ERR_W-DB_W){1'b0}}, deadband_ff}) ? '0 : err_in;
   end

   // stage 1: state memory read-modify-write
   joint_state_type           state_mem [2];
   joint_state_type           rd_state_ff, fwd_state_ff, wr_state_in, cur_state;
   logic [1:0]                seen_ff;
   logic                      rd_seen_ff, fwd_hit_ff, cur_seen, sp_changed;
   logic [JOINT_W-1:0]        s1_joint_ff;
   logic signed [ANGLE_W-1:0] s1_setpoint_ff, s1_measured_ff, last_base;
   logic signed [QUOT_W-1:0]  s1_quot_ff;
   logic signed [ERR_W-1:0]   s1_ep_ff, diff_in;
   logic signed [INTEG_W-1:0] int_base, integral_in;
   logic signed [INTEG_W:0]   int_sum;
   logic [GAIN_W-1:0]         kp_in, ki_in, kd_in;

   always_ff @(posedge clock) begin
      if (wr_en) state_mem[s1_joint_ff] <= wr_state_in;
      if (req_fire) begin
         rd_state_ff    <= state_mem[req_joint];
         rd_seen_ff     <= seen_ff[req_joint];
         fwd_hit_ff     <= wr_en && (s1_joint_ff == req_joint);
         fwd_state_ff   <= wr_state_in;
         s1_joint_ff    <= req_joint;
         s1_setpoint_ff <= req_setpoint;
         s1_measured_ff <= req_measured;
         s1_quot_ff     <= quot_in;
         s1_ep_ff       <= ep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (wr_en) begin
         seen_ff[s1_joint_ff] <= 1'b1;
      end
   end

   always_comb begin
      cur_state  = fwd_hit_ff ? fwd_state_ff : rd_state_ff;
      cur_seen   = fwd_hit_ff || rd_seen_ff;
      sp_changed = cur_seen && (cur_state.setpoint != s1_setpoint_ff);
      int_base   = (cur_seen && !sp_changed) ? cur_state.integral : '0;
      last_base  = cur_seen ? cur_state.last_pos : '0;
      int_sum    = {int_base[INTEG_W-1], int_base}
                 + {{(INTEG_W+1-QUOT_W){s1_quot_ff[QUOT_W-1]}}, s1_quot_ff};
      if (int_sum[INTEG_W] != int_sum[INTEG_W-1]) begin
         integral_in = int_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                        : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integral_in = int_sum[INTEG_W-1:0];
      end
      diff_in = {last_base[ANGLE_W-1], last_base}
              - {s1_measured_ff[ANGLE_W-1], s1_measured_ff};
      wr_state_in.setpoint = s1_setpoint_ff;
      wr_state_in.integral = integral_in;
      wr_state_in.last_pos = s1_measured_ff;
      unique case (s1_joint_ff)
         JOINT_SHOULDER: begin
            kp_in = kp_shoulder_ff;
            ki_in = ki_shoulder_ff;
            kd_in = kd_shoulder_ff;
         end
         JOINT_ELBOW: begin
            kp_in = kp_elbow_ff;
            ki_in = ki_elbow_ff;
            kd_in = kd_elbow_ff;
         end
         default: begin
            kp_in = kp_shoulder_ff;
            ki_in = ki_shoulder_ff;
            kd_in = kd_shoulder_ff;
         end
      endcase
   end

   // stage 2: operands
   logic [JOINT_W-1:0]        s2_joint_ff;
   logic signed [ERR_W-1:0]   s2_ep_ff, s2_diff_ff;
   logic signed [INTEG_W-1:0] s2_integral_ff;
   logic [GAIN_W-1:0]         s2_kp_ff, s2_ki_ff, s2_kd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         s2_joint_ff    <= s1_joint_ff;
         s2_ep_ff       <= s1_ep_ff;
         s2_diff_ff     <= diff_in;
         s2_integral_ff <= integral_in;
         s2_kp_ff       <= kp_in;
         s2_ki_ff       <= ki_in;
         s2_kd_ff       <= kd_in;
      end
   end

   // stage 3: products
   logic [JOINT_W-1:0]          s3_joint_ff;
   logic signed [PD_PROD_W-1:0] p_prod_in, d_prod_in, s3_p_ff, s3_d_ff;
   logic signed [I_PROD_W-1:0]  i_prod_in, s3_i_ff;

   assign p_prod_in = $signed({1'b0, s2_kp_ff}) * s2_ep_ff;
   assign i_prod_in = $signed({1'b0, s2_ki_ff}) * s2_integral_ff;
   assign d_prod_in = $signed({1'b0, s2_kd_ff}) * s2_diff_ff;

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s3_ready) begin
         s3_joint_ff <= s2_joint_ff;
         s3_p_ff     <= p_prod_in;
         s3_i_ff     <= i_prod_in;
         s3_d_ff     <= d_prod_in;
      end
   end

   // stage 4: sum
   logic [JOINT_W-1:0]      s4_joint_ff;
   logic signed [ACC_W-1:0] acc_in, s4_acc_ff;

   assign acc_in = ACC_W'(s3_p_ff) + ACC_W'(s3_i_ff) + ACC_W'(s3_d_ff);

   always_ff @(posedge clock) begin
      if (s3_valid_ff && s4_ready) begin
         s4_joint_ff <= s3_joint_ff;
         s4_acc_ff   <= acc_in;
      end
   end

   // result: scale toward zero, saturate
   logic signed [ACC_W-1:0]   biased;
   logic signed [SHIFT_W-1:0] shifted;
   logic [SHIFT_W-DRIVE_W:0]  upper;
   logic signed [DRIVE_W-1:0] drive_in, rsp_drive_ff;
   logic [JOINT_W-1:0]        rsp_joint_ff;

   always_comb begin
      biased  = s4_acc_ff
              + {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{s4_acc_ff[ACC_W-1]}}};
      shifted = biased[ACC_W-1:FRAC_BITS];
      upper   = shifted[SHIFT_W-1:DRIVE_W-1];
      if ((&upper) || !(|upper)) begin
         drive_in = shifted[DRIVE_W-1:0];
      end else begin
         drive_in = shifted[SHIFT_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                       : {1'b0, {(DRIVE_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (s4_valid_ff && rsp_en) begin
         rsp_drive_ff <= drive_in;
         rsp_joint_ff <= s4_joint_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_out_joint = rsp_joint_ff;

   `ASSERT_NEXT(a_wb_marks_seen, clock, reset, wr_en, seen_ff[$past(s1_joint_ff)])
   `ASSERT_NEXT(a_seen_sticky_sh, clock, reset, seen_ff[0], seen_ff[0])
   `ASSERT_NEXT(a_seen_sticky_el, clock, reset, seen_ff[1], seen_ff[1])
   `ASSERT_IMPLIES(a_stall_needs_item, clock, reset, !req_ready, s1_valid_ff && s2_valid_ff)

endmodule

`default_nettype wire

>>> tb/tjpid_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tjpid_checker
// Watches the request, response and csr channels of the two-joint PID block.
// Keeps its own copy of gains, deadband and per-joint state. Predicts the
// drive value of every accepted request and compares each returned response,
// in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module tjpid_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_ready,
   input  wire logic [tjpid_pkg::JOINT_W-1:0]        req_joint,
   input  wire logic signed [tjpid_pkg::ANGLE_W-1:0] req_setpoint,
   input  wire logic signed [tjpid_pkg::ANGLE_W-1:0] req_measured,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire logic signed [tjpid_pkg::DRIVE_W-1:0] rsp_drive,
   input  wire logic [tjpid_pkg::JOINT_W-1:0]        rsp_out_joint,
   input  wire logic                                 csr_valid,
   input  wire logic                                 csr_ready,
   input  wire logic [tjpid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tjpid_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                        fail_count,
   output int                                        pending,
   output int                                        req_count,
   output int                                        rsp_count
);

   import tjpid_pkg::*;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam int     REPORT_LIMIT = 10;

   typedef struct {
      logic signed [DRIVE_W-1:0] drive;
      logic [JOINT_W-1:0]        joint;
   } drive_entry_type;

   drive_entry_type expected_drive_q[$];

   logic [GAIN_W-1:0]         gain_reg [6];
   logic [DB_W-1:0]           deadband_reg;
   logic signed [ANGLE_W-1:0] held_setpoint [2];
   logic                      setpoint_held [2];
   logic signed [INTEG_W-1:0] integ_sum [2];
   logic signed [ANGLE_W-1:0] prev_pos [2];

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > S32_MAX) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < S32_MIN) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic drive_entry_type pid_drive(input logic [JOINT_W-1:0] j,
                                                 input logic signed [ANGLE_W-1:0] sp,
                                                 input logic signed [ANGLE_W-1:0] meas);
      int base;
      longint kp, ki, kd, err, ep, diff, acc;
      drive_entry_type r;
      base = (j == JOINT_ELBOW) ? int'(REG_KP_ELBOW) : int'(REG_KP_SHOULDER);
      kp = longint'(gain_reg[base]);
      ki = longint'(gain_reg[base + 1]);
      kd = longint'(gain_reg[base + 2]);
      if (!setpoint_held[j]) begin
         setpoint_held[j] = 1'b1;
         held_setpoint[j] = sp;
      end else if (held_setpoint[j] != sp) begin
         held_setpoint[j] = sp;
         integ_sum[j] = '0;
      end
      err = longint'(sp) - longint'(meas);
      integ_sum[j] = clamp32(longint'(integ_sum[j]) + err / 10);
      diff = longint'(prev_pos[j]) - longint'(meas);
      ep = (((err < 0) ? -err : err) < longint'(deadband_reg)) ? 0 : err;
      acc = kp * ep + ki * longint'(integ_sum[j]) + kd * diff;
      r.drive = clamp32(acc / (longint'(1) << FRAC_BITS));
      r.joint = j;
      prev_pos[j] = meas;
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%t mismatch: %s", $realtime, what);
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      req_count = 0;
      rsp_count = 0;
   end

   always @(posedge clock) begin
      drive_entry_type want;
      if (reset) begin
         gain_reg[REG_KP_SHOULDER] = KP_SHOULDER_RST;
         gain_reg[REG_KI_SHOULDER] = KI_SHOULDER_RST;
         gain_reg[REG_KD_SHOULDER] = KD_SHOULDER_RST;
         gain_reg[REG_KP_ELBOW]    = KP_ELBOW_RST;
         gain_reg[REG_KI_ELBOW]    = KI_ELBOW_RST;
         gain_reg[REG_KD_ELBOW]    = KD_ELBOW_RST;
         deadband_reg = DEADBAND_RST;
         for (int i = 0; i < 2; i++) begin
            held_setpoint[i] = '0;
            setpoint_held[i] = 1'b0;
            integ_sum[i] = '0;
            prev_pos[i] = '0;
         end
         expected_drive_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_drive_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected drive %0d for joint %0d",
                                       rsp_drive, rsp_out_joint));
            end else begin
               want = expected_drive_q.pop_front();
               if (want.drive !== rsp_drive || want.joint !== rsp_out_joint) begin
                  flag_mismatch($sformatf("drive exp %0d got %0d, joint exp %0d got %0d",
                                          want.drive, rsp_drive, want.joint, rsp_out_joint));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index < REG_DEADBAND) begin
               gain_reg[csr_index] = csr_data;
            end else if (csr_index == REG_DEADBAND) begin
               deadband_reg = csr_data[DB_W-1:0];
            end
         end
         if (req_valid && req_ready) begin
            req_count++;
            expected_drive_q.push_back(pid_drive(req_joint, req_setpoint, req_measured));
         end
      end
      pending = expected_drive_q.size();
   end

endmodule

>>> tb/tb_two_joint_pid_with_deadband.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_joint_pid_with_deadband
// Stimulus and verdict for the two-joint PID block. Runs directed corner
// transactions, a short full-rate stream that alternates the joints, then
// random setpoint runs under several gain settings with bursty requests and
// a stalling response side. Checking is in tjpid_checker.
// ----------------------------------------------------------------------------
module tb_two_joint_pid_with_deadband;

   import tjpid_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SOAK_PAIRS     = 16;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_ITEMS    = 180;
   localparam int DRAIN_CYCLES   = 16;
   localparam int RESET_CYCLES   = 11;

   localparam logic [CSR_IDX_W-1:0]      REG_UNUSED = 3'd7;
   localparam logic [GAIN_W-1:0]         GAIN_MAX   = '1;
   localparam logic [GAIN_W-1:0]         GAIN_ZERO  = '0;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX  = 16'sh7FFF;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN  = 16'sh8000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [JOINT_W-1:0]        req_joint = '0;
   logic signed [ANGLE_W-1:0] req_setpoint = '0;
   logic signed [ANGLE_W-1:0] req_measured = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive;
   logic [JOINT_W-1:0]        rsp_out_joint;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   int fail_count, pending, req_count, rsp_count;
   int idle_cycles = 0;
   int burst_left = 0;
   int settings_applied = 0;
   int ready_mode = 0;
   int ready_left = 0;
   logic full_rate = 1'b0;
   logic signed [ANGLE_W-1:0] cur_sp [2] = '{16'sd0, 16'sd0};
   logic [DB_W-1:0] cur_db = DEADBAND_RST;

   two_joint_pid_with_deadband u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_joint     (req_joint),
      .req_setpoint  (req_setpoint),
      .req_measured  (req_measured),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_drive     (rsp_drive),
      .rsp_out_joint (rsp_out_joint),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   tjpid_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_joint     (req_joint),
      .req_setpoint  (req_setpoint),
      .req_measured  (req_measured),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_drive     (rsp_drive),
      .rsp_out_joint (rsp_out_joint),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .req_count     (req_count),
      .rsp_count     (rsp_count)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_left <= $urandom_range(4, 40);
      end else begin
         ready_left <= ready_left - 1;
      end
      if (full_rate) begin
         rsp_ready <= 1'b1;
      end else begin
         case (ready_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_ready <= ($urandom_range(0, 5) == 0);
            end
            default: begin
               rsp_ready <= ~rsp_ready;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[two_joint_pid_with_deadband] ERROR");
         $finish;
      end
   end

   task automatic send_item(input logic [JOINT_W-1:0] j,
                            input logic signed [ANGLE_W-1:0] sp,
                            input logic signed [ANGLE_W-1:0] m);
      req_valid <= 1'b1;
      req_joint <= j;
      req_setpoint <= sp;
      req_measured <= m;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_paced(input logic [JOINT_W-1:0] j,
                             input logic signed [ANGLE_W-1:0] sp,
                             input logic signed [ANGLE_W-1:0] m);
      int gap;
      send_item(j, sp, m);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [GAIN_W-1:0] kps, kis, kds,
                               input logic [GAIN_W-1:0] kpe, kie, kde,
                               input logic [CSR_DATA_W-1:0] dbv);
      wait_drained();
      write_csr(REG_UNUSED, CSR_DATA_W'($urandom));
      write_csr(REG_KP_SHOULDER, kps);
      write_csr(REG_KI_SHOULDER, kis);
      write_csr(REG_KD_SHOULDER, kds);
      write_csr(REG_KP_ELBOW, kpe);
      write_csr(REG_KI_ELBOW, kie);
      write_csr(REG_KD_ELBOW, kde);
      write_csr(REG_DEADBAND, dbv);
      csr_valid <= 1'b0;
      cur_db = dbv[DB_W-1:0];
      settings_applied++;
   endtask

   task automatic send_random_item();
      logic [JOINT_W-1:0] j;
      logic signed [ANGLE_W-1:0] m;
      int span, off;
      j = JOINT_W'($urandom_range(0, 1));
      if ($urandom_range(0, 11) == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            cur_sp[j] = $urandom_range(0, 1) ? ANGLE_MAX : ANGLE_MIN;
         end else begin
            cur_sp[j] = ANGLE_W'($urandom);
         end
      end
      span = int'(cur_db) + 3;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            off = int'($urandom_range(0, 2 * span)) - span;
         end
         5, 6, 7: begin
            off = int'(ANGLE_W'($urandom));
         end
         8: begin
            off = $urandom_range(0, 1) ? int'(ANGLE_MAX) : int'(ANGLE_MIN);
            off = off - int'(cur_sp[j]);
         end
         default: begin
            off = int'(cur_db) - int'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) begin
               off = -off;
            end
         end
      endcase
      m = cur_sp[j] + ANGLE_W'(off);
      send_paced(j, cur_sp[j], m);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_paced(JOINT_SHOULDER, 16'sd100, 16'sd0);
      send_paced(JOINT_SHOULDER, 16'sd100, 16'sd97);
      send_paced(JOINT_SHOULDER, 16'sd100, 16'sd95);
      send_paced(JOINT_SHOULDER, 16'sd100, 16'sd104);
      send_paced(JOINT_SHOULDER, -16'sd200, -16'sd190);
      send_paced(JOINT_ELBOW, ANGLE_MAX, ANGLE_MIN);
      send_paced(JOINT_ELBOW, ANGLE_MIN, ANGLE_MAX);
      send_paced(JOINT_ELBOW, ANGLE_MIN, ANGLE_MIN);
      send_paced(JOINT_SHOULDER, 16'sd0, 16'sd0);

      apply_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, '0);
      send_paced(JOINT_SHOULDER, ANGLE_MAX, ANGLE_MIN);
      send_paced(JOINT_SHOULDER, ANGLE_MIN, ANGLE_MAX);
      send_paced(JOINT_ELBOW, 16'sd1, 16'sd0);
      send_paced(JOINT_ELBOW, 16'sd1, 16'sd1);
      send_paced(JOINT_ELBOW, 16'sd1, ANGLE_MIN);

      apply_config(GAIN_ZERO, GAIN_ZERO, GAIN_MAX, GAIN_ZERO, GAIN_ZERO, GAIN_MAX, 24'hFFFFFF);
      send_paced(JOINT_SHOULDER, 16'sd0, ANGLE_MAX);
      send_paced(JOINT_SHOULDER, 16'sd0, ANGLE_MIN);
      send_paced(JOINT_ELBOW, 16'sd5, -16'sd100);
      send_paced(JOINT_ELBOW, 16'sd5, 16'sd300);

      // hold full rate with the joints interleaved
      apply_config(GAIN_ZERO, 24'd1, GAIN_ZERO, GAIN_ZERO, 24'd1, GAIN_ZERO, '0);
      full_rate <= 1'b1;
      for (int i = 0; i < SOAK_PAIRS; i++) begin
         send_item(JOINT_SHOULDER, ANGLE_MAX, ANGLE_MIN);
         send_item(JOINT_ELBOW, ANGLE_MIN, ANGLE_MAX);
      end
      wait_drained();
      full_rate <= 1'b0;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               apply_config(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                            GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                            CSR_DATA_W'($urandom));
            end
            1: begin
               apply_config(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO,
                            GAIN_ZERO, '0);
            end
            2: begin
               apply_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
                            24'hFFFFFF);
            end
            3: begin
               apply_config(GAIN_W'($urandom_range(0, 2**20 - 1)),
                            GAIN_W'($urandom_range(0, 2**16 - 1)),
                            GAIN_W'($urandom_range(0, 2**20 - 1)),
                            GAIN_W'($urandom_range(0, 2**20 - 1)),
                            GAIN_W'($urandom_range(0, 2**16 - 1)),
                            GAIN_W'($urandom_range(0, 2**20 - 1)),
                            CSR_DATA_W'($urandom_range(0, 32)));
            end
            default: begin
               apply_config(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                            GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                            CSR_DATA_W'($urandom_range(0, 255)));
            end
         endcase
         repeat (PHASE_ITEMS) send_random_item();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d transactions sent, %0d drive values checked, %0d register settings",
               req_count, rsp_count, settings_applied);
      $display("summary: deadband edges, setpoint changes, drive saturation, joint interleave");
      if (fail_count == 0 && pending == 0) begin
         $display("[two_joint_pid_with_deadband] OK");
      end else begin
         $display("[two_joint_pid_with_deadband] ERROR");
      end
      $finish;
   end

endmodule
